@@ src/four_level_page_table_walker_core_macros.svh @@
// Assertion macros shared by the page table walker RTL.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Checks that an implication holds at every clock edge outside reset.
`define PTW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks that a trigger is followed by a consequence in the next cycle.
`define PTW_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);
`else
`define PTW_ASSERT(lbl, clk, rst_n, prop, msg)
`define PTW_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg)
`endif
`endif

@@ src/ptw_pkg.sv @@
// Shared types, constants and helper functions of the page table walker.
package ptw_pkg;

  // Default sizing of the table store.
  localparam int TABLE_FRAMES_DEF = 64;
  localparam int NUM_SPACES_DEF   = 4;

  // Field widths.
  localparam int OP_W     = 2;
  localparam int SPACE_W  = 2;
  localparam int VA_W     = 48;
  localparam int PA_W     = 52;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 43;
  localparam int FRAME_W  = 40;
  localparam int IDX_W    = 9;
  localparam int OFFS_W   = 12;
  localparam int LVL_W    = 2;

  // Walk level that holds the leaf entry.
  localparam logic [LVL_W-1:0] LEAF_LVL = 2'd3;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_MAP    = 2'd0;
  localparam logic [OP_W-1:0] OP_UNMAP  = 2'd1;
  localparam logic [OP_W-1:0] OP_XLATE  = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FRAMES  = 2'd2;

  // Entry flag bits: present, writable, user.
  localparam logic [2:0] FLAGS_PWU = 3'b111;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [SPACE_W-1:0] space_id;
    logic [VA_W-1:0]    virt_addr;
    logic [PA_W-1:0]    phys_addr;
    logic               writable;
    logic               user_access;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PA_W-1:0]     result_addr;
  } res_t;

  // Table index of one walk level, top level first.
  function automatic logic [IDX_W-1:0] level_idx(input logic [VA_W-1:0] va,
                                                  input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    begin
      unique case (lvl)
        2'd0:    idx = va[47:39];
        2'd1:    idx = va[38:30];
        2'd2:    idx = va[29:21];
        default: idx = va[20:12];
      endcase
      return idx;
    end
  endfunction

endpackage

@@ src/ptw_ifs.sv @@
// Valid/ready channel interfaces for requests and results of the walker.
interface ptw_req_if;
  logic                         valid;
  logic                         ready;
  logic [ptw_pkg::OP_W-1:0]     operation;
  logic [ptw_pkg::SPACE_W-1:0]  space_id;
  logic [ptw_pkg::VA_W-1:0]     virt_addr;
  logic [ptw_pkg::PA_W-1:0]     phys_addr;
  logic                         writable;
  logic                         user_access;

  modport source (output valid, operation, space_id, virt_addr, phys_addr, writable,
                  user_access, input ready);
  modport sink (input valid, operation, space_id, virt_addr, phys_addr, writable,
                user_access, output ready);
endinterface

interface ptw_res_if;
  logic                          valid;
  logic                          ready;
  logic [ptw_pkg::STATUS_W-1:0]  status;
  logic [ptw_pkg::PA_W-1:0]      result_addr;

  modport source (output valid, status, result_addr, input ready);
  modport sink (input valid, status, result_addr, output ready);
endinterface

@@ src/ptw_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module ptw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/ptw_seq.sv @@
// Walk sequencer: clears the table store, then reads, updates and links table entries.
`include "four_level_page_table_walker_core_macros.svh"
module ptw_seq #(
  parameter int TABLE_FRAMES = ptw_pkg::TABLE_FRAMES_DEF,
  parameter int NUM_SPACES   = ptw_pkg::NUM_SPACES_DEF,
  localparam int DEPTH = TABLE_FRAMES * 512,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         req_valid_i,
  input  ptw_pkg::req_t                req_i,
  output logic                         req_ready_o,
  output logic                         done_o,
  output ptw_pkg::res_t                res_o,
  input  logic                         res_room_i,
  output logic                         ram_we_o,
  output logic [AW-1:0]                ram_waddr_o,
  output logic [ptw_pkg::ENTRY_W-1:0]  ram_wdata_o,
  output logic                         ram_re_o,
  output logic [AW-1:0]                ram_raddr_o,
  input  logic [ptw_pkg::ENTRY_W-1:0]  ram_rdata_i
);

  localparam int FW     = $clog2(TABLE_FRAMES);
  localparam int NF_MAX = (TABLE_FRAMES > NUM_SPACES) ? TABLE_FRAMES : NUM_SPACES;
  localparam int NFW    = $clog2(NF_MAX + 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                              state_r, state_nxt;
  logic [ptw_pkg::OP_W-1:0]            op_r, op_nxt;
  logic [ptw_pkg::VA_W-1:0]            va_r, va_nxt;
  logic [ptw_pkg::FRAME_W-1:0]         pfn_r, pfn_nxt;
  logic                                wr_r, wr_nxt;
  logic                                us_r, us_nxt;
  logic [FW-1:0]                       tbl_r, tbl_nxt;
  logic [ptw_pkg::LVL_W-1:0]           lvl_r, lvl_nxt;
  logic [NFW-1:0]                      nf_r, nf_nxt;
  logic [AW-1:0]                       addr_r, addr_nxt;
  logic [AW-1:0]                       clr_r, clr_nxt;
  ptw_pkg::res_t                       res_r, res_nxt;

  logic [ptw_pkg::FRAME_W-1:0]         ent_frame;
  logic                                link_ok;
  logic                                out_of_frames;
  logic                                space_bad;

  assign ent_frame     = ram_rdata_i[ptw_pkg::ENTRY_W-1:3];
  assign link_ok       = ram_rdata_i[0] &&
                         (ent_frame < ptw_pkg::FRAME_W'(TABLE_FRAMES));
  assign out_of_frames = (nf_r >= NFW'(TABLE_FRAMES));
  assign space_bad     = ({30'd0, req_i.space_id} >= 32'(NUM_SPACES));

  assign req_ready_o = (state_r == S_IDLE);
  assign done_o      = (state_r == S_DONE);
  assign res_o       = res_r;

  // Next-state and datapath logic of the walk.
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    va_nxt      = va_r;
    pfn_nxt     = pfn_r;
    wr_nxt      = wr_r;
    us_nxt      = us_r;
    tbl_nxt     = tbl_r;
    lvl_nxt     = lvl_r;
    nf_nxt      = nf_r;
    addr_nxt    = addr_r;
    clr_nxt     = clr_r;
    res_nxt     = res_r;
    ram_we_o    = 1'b0;
    ram_waddr_o = addr_r;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = {tbl_r, ptw_pkg::level_idx(va_r, lvl_r)};

    unique case (state_r)
      S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_r;
        clr_nxt     = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid_i) begin
          op_nxt  = req_i.operation;
          va_nxt  = req_i.virt_addr;
          pfn_nxt = req_i.phys_addr[ptw_pkg::PA_W-1:ptw_pkg::OFFS_W];
          wr_nxt  = req_i.writable;
          us_nxt  = req_i.user_access;
          tbl_nxt = FW'(req_i.space_id);
          lvl_nxt = '0;
          res_nxt = '{status: ptw_pkg::ST_OK, result_addr: '0};
          if (req_i.operation == ptw_pkg::OP_UNUSED) begin
            state_nxt = S_DONE;
          end else if (space_bad) begin
            res_nxt.status = ptw_pkg::ST_NOT_MAPPED;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        ram_re_o  = 1'b1;
        addr_nxt  = ram_raddr_o;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (lvl_r != ptw_pkg::LEAF_LVL) begin
          // Intermediate level: follow the link, create a table, or stop.
          if (link_ok) begin
            tbl_nxt   = ent_frame[FW-1:0];
            lvl_nxt   = lvl_r + 2'd1;
            state_nxt = S_READ;
          end else if (op_r == ptw_pkg::OP_MAP) begin
            if (out_of_frames) begin
              res_nxt.status = ptw_pkg::ST_NO_FRAMES;
              state_nxt      = S_DONE;
            end else begin
              ram_we_o    = 1'b1;
              ram_wdata_o = {ptw_pkg::FRAME_W'(nf_r), ptw_pkg::FLAGS_PWU};
              tbl_nxt     = nf_r[FW-1:0];
              nf_nxt      = nf_r + NFW'(1);
              lvl_nxt     = lvl_r + 2'd1;
              state_nxt   = S_READ;
            end
          end else begin
            if (op_r == ptw_pkg::OP_XLATE) begin
              res_nxt.status = ptw_pkg::ST_NOT_MAPPED;
            end
            state_nxt = S_DONE;
          end
        end else begin
          // Leaf level: write, clear or look up the page entry.
          unique case (op_r)
            ptw_pkg::OP_MAP: begin
              ram_we_o    = 1'b1;
              ram_wdata_o = {pfn_r, us_r, wr_r, 1'b1};
            end
            ptw_pkg::OP_UNMAP: begin
              ram_we_o = 1'b1;
            end
            ptw_pkg::OP_XLATE: begin
              if (ram_rdata_i[0]) begin
                res_nxt.result_addr = {ent_frame, va_r[ptw_pkg::OFFS_W-1:0]};
              end else begin
                res_nxt.status = ptw_pkg::ST_NOT_MAPPED;
              end
            end
            default: begin
              res_nxt.status = ptw_pkg::ST_OK;
            end
          endcase
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_room_i) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      nf_r    <= NFW'(NUM_SPACES);
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      nf_r    <= nf_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    va_r   <= va_nxt;
    pfn_r  <= pfn_nxt;
    wr_r   <= wr_nxt;
    us_r   <= us_nxt;
    tbl_r  <= tbl_nxt;
    lvl_r  <= lvl_nxt;
    addr_r <= addr_nxt;
    res_r  <= res_nxt;
  end

  // A table frame is handed out only while a map walks an intermediate level.
  `PTW_ASSERT(a_alloc_on_map, clk, rst_n, (nf_nxt != nf_r) |-> (state_r == S_EVAL && op_r == ptw_pkg::OP_MAP && lvl_r != ptw_pkg::LEAF_LVL && !out_of_frames), "table frame allocated outside a map walk")
  // Every table read is evaluated in the following cycle.
  `PTW_ASSERT_NEXT(a_read_then_eval, clk, rst_n, ram_re_o, state_r == S_EVAL, "read data not evaluated")
  // Leaf writes come only from map and unmap.
  `PTW_ASSERT(a_leaf_write_op, clk, rst_n, (ram_we_o && state_r == S_EVAL && lvl_r == ptw_pkg::LEAF_LVL) |-> (op_r == ptw_pkg::OP_MAP || op_r == ptw_pkg::OP_UNMAP), "leaf written by wrong operation")

endmodule

@@ src/four_level_page_table_walker_core.sv @@
// Keeps four-level 512-entry page tables in an internal store and serves map, unmap and
// translate requests. After reset the block sweeps the whole table store to zero, one entry
// per cycle, over all TABLE_FRAMES * 512 entries (32768 with the defaults); no item is
// accepted during that sweep. A walk then takes one read and one evaluate step per table
// level on the single table memory, so a full walk is an accept step, four read/evaluate
// pairs and a step that hands the result to the output register. A request with the unused
// operation code or an address space without a table skips the table reads.
// The next item is accepted while a finished result still waits at the output.
module four_level_page_table_walker_core #(
  parameter int TABLE_FRAMES = ptw_pkg::TABLE_FRAMES_DEF,
  parameter int NUM_SPACES   = ptw_pkg::NUM_SPACES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ptw_req_if.sink   in_ch,
  ptw_res_if.source out_ch
);

  localparam int DEPTH = TABLE_FRAMES * 512;
  localparam int AW    = $clog2(DEPTH);

  ptw_pkg::req_t                req;
  ptw_pkg::res_t                seq_res;
  logic                         seq_done;
  logic                         res_room;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [ptw_pkg::ENTRY_W-1:0]  ram_wdata;
  logic                         ram_re;
  logic [AW-1:0]                ram_raddr;
  logic [ptw_pkg::ENTRY_W-1:0]  ram_rdata;
  logic                         out_valid_r, out_valid_nxt;
  ptw_pkg::res_t                out_res_r;

  // Gather the request fields.
  assign req = '{operation:   in_ch.operation,
                 space_id:    in_ch.space_id,
                 virt_addr:   in_ch.virt_addr,
                 phys_addr:   in_ch.phys_addr,
                 writable:    in_ch.writable,
                 user_access: in_ch.user_access};

  ptw_seq #(
    .TABLE_FRAMES (TABLE_FRAMES),
    .NUM_SPACES   (NUM_SPACES)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid_i (in_ch.valid),
    .req_i       (req),
    .req_ready_o (in_ch.ready),
    .done_o      (seq_done),
    .res_o       (seq_res),
    .res_room_i  (res_room),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  ptw_ram #(
    .WIDTH (ptw_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: loads a finished result when it is empty or being drained.
  assign res_room      = !out_valid_r || out_ch.ready;
  assign out_valid_nxt = (seq_done && res_room) || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done && res_room) begin
      out_res_r <= seq_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.result_addr = out_res_r.result_addr;

endmodule
